[sv/madp95_pkg.sv]
// madp95_pkg: shared constants, controller states and command/status structs
// for the masked absolute difference mean and 95th percentile unit
// no dependencies
`timescale 1ns / 1ps

package madp95_pkg;

  // default configuration
  localparam int unsigned MAX_SAMPLES_DEF = 16384;
  localparam int unsigned PIXEL_BITS_DEF  = 16;

  // result field widths
  localparam int unsigned COUNT_W = 15;
  localparam int unsigned MEAN_W  = 16;
  localparam int unsigned P95_W   = 16;

  // percentile arithmetic constants
  localparam int unsigned PCT_NUM  = 95;
  localparam int unsigned PCT_DEN  = 100;
  localparam int unsigned PCT_HALF = 50;
  localparam int unsigned FRAC_W   = 7;

  // divider operand selection
  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_IDX,
    DIV_P95
  } div_sel_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MEAN,
    S_IDX_GO,
    S_IDX,
    S_SEL_RD,
    S_SEL_DRAIN,
    S_SEL_UPD,
    S_MUL,
    S_P95_GO,
    S_P95,
    S_DONE
  } ctl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     take;
    logic     div_go;
    div_sel_t div_sel;
    logic     cap_zero;
    logic     cap_mean;
    logic     cap_idx;
    logic     sel_rd;
    logic     sel_upd;
    logic     mul;
    logic     cap_p95;
    logic     load_out;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic n_zero;
    logic div_done;
    logic addr_last;
    logic bit_last;
    logic out_free;
  } dp_sts_t;

endpackage

[sv/madp95_if.sv]
// madp95_in_if / madp95_out_if: valid/ready channels for pixel items and results
// depends on madp95_pkg
`timescale 1ns / 1ps

interface madp95_in_if #(
  parameter int unsigned PIXEL_BITS = madp95_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] ref_pixel;
  logic [PIXEL_BITS-1:0] dist_pixel;
  logic                  in_mask;
  logic                  last_pixel;

  modport source (output valid, ref_pixel, dist_pixel, in_mask, last_pixel, input ready);
  modport sink   (input valid, ref_pixel, dist_pixel, in_mask, last_pixel, output ready);
endinterface

interface madp95_out_if;
  logic                           valid;
  logic                           ready;
  logic [madp95_pkg::COUNT_W-1:0] masked_count;
  logic [madp95_pkg::MEAN_W-1:0]  mean_abs_diff;
  logic [madp95_pkg::P95_W-1:0]   p95_abs_diff;
  logic                           overflowed;

  modport source (output valid, masked_count, mean_abs_diff, p95_abs_diff, overflowed,
                  input ready);
  modport sink   (input valid, masked_count, mean_abs_diff, p95_abs_diff, overflowed,
                  output ready);
endinterface

[sv/madp95_div.sv]
// madp95_div: restoring divider, one quotient bit per cycle
// depends on nothing
`timescale 1ns / 1ps

module madp95_div #(
  parameter int unsigned NW  = 32,
  parameter int unsigned DVW = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  num,
  input  logic [DVW-1:0] den,
  output logic           done,
  output logic [NW-1:0]  quot
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [DVW-1:0]   den_r;
  logic [DVW-1:0]   rem_r;
  logic [NW-1:0]    quot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVW:0]     trial;
  logic             qbit;

  // one shift and subtract step
  always_comb begin
    trial = {rem_r, quot_r[NW-1]};
    qbit  = (trial >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= num;
    end else if (busy_r) begin
      rem_r  <= qbit ? DVW'(trial - {1'b0, den_r}) : DVW'(trial);
      quot_r <= {quot_r[NW-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[sv/madp95_ctrl.sv]
// madp95_ctrl: frame sequencer, drives datapath commands
// depends on madp95_pkg
`timescale 1ns / 1ps

module madp95_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  madp95_pkg::dp_sts_t sts,
  output madp95_pkg::dp_cmd_t cmd
);
  import madp95_pkg::*;

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid && in_last) state_nxt = S_START;
      S_START:     state_nxt = sts.n_zero ? S_DONE : S_MEAN;
      S_MEAN:      if (sts.div_done) state_nxt = S_IDX_GO;
      S_IDX_GO:    state_nxt = S_IDX;
      S_IDX:       if (sts.div_done) state_nxt = S_SEL_RD;
      S_SEL_RD:    if (sts.addr_last) state_nxt = S_SEL_DRAIN;
      S_SEL_DRAIN: state_nxt = S_SEL_UPD;
      S_SEL_UPD:   state_nxt = sts.bit_last ? S_MUL : S_SEL_RD;
      S_MUL:       state_nxt = S_P95_GO;
      S_P95_GO:    state_nxt = S_P95;
      S_P95:       if (sts.div_done) state_nxt = S_DONE;
      S_DONE:      if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.div_sel = DIV_MEAN;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_START: begin
        cmd.cap_zero = sts.n_zero;
        cmd.div_go   = !sts.n_zero;
        cmd.div_sel  = DIV_MEAN;
      end
      S_MEAN:   cmd.cap_mean = sts.div_done;
      S_IDX_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_IDX;
      end
      S_IDX:       cmd.cap_idx = sts.div_done;
      S_SEL_RD:    cmd.sel_rd  = 1'b1;
      S_SEL_DRAIN: ;
      S_SEL_UPD:   cmd.sel_upd = 1'b1;
      S_MUL:       cmd.mul     = 1'b1;
      S_P95_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_P95;
      end
      S_P95:  cmd.cap_p95  = sts.div_done;
      S_DONE: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

[sv/madp95_dpath.sv]
// madp95_dpath: difference store, running sum, radix selection of two order
// statistics, serial mean divider, reciprocal divide by 100 and result register
// depends on madp95_pkg, madp95_div
`timescale 1ns / 1ps

module madp95_dpath #(
  parameter int unsigned MAX_SAMPLES = madp95_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned PIXEL_BITS  = madp95_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  madp95_pkg::dp_cmd_t                cmd,
  output madp95_pkg::dp_sts_t                sts,
  input  logic [PIXEL_BITS-1:0]              ref_pixel,
  input  logic [PIXEL_BITS-1:0]              dist_pixel,
  input  logic                               in_mask,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [madp95_pkg::COUNT_W-1:0]     masked_count,
  output logic [madp95_pkg::MEAN_W-1:0]      mean_abs_diff,
  output logic [madp95_pkg::P95_W-1:0]       p95_abs_diff,
  output logic                               overflowed
);
  import madp95_pkg::*;

  localparam int unsigned PB   = PIXEL_BITS;
  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned SW   = PB + CW;
  localparam int unsigned NW0  = (PB + CW + 1 > PB + 7) ? PB + CW + 1 : PB + 7;
  localparam int unsigned NW   = (NW0 > 17) ? NW0 : 17;
  localparam int unsigned DVW  = (CW > FRAC_W) ? CW : FRAC_W;
  localparam int unsigned BW   = $clog2(PB);
  localparam int unsigned PW   = PB + FRAC_W;
  // reciprocal divide by 100: operand width, shift, multiplier and quotient widths
  localparam int unsigned RW   = (PW > CW + 7) ? PW : CW + 7;
  localparam int unsigned RS   = RW + 7;
  localparam int unsigned RMW  = RS - 6;
  localparam int unsigned QW   = RW - 6;
  localparam int unsigned RPW  = RW + RMW;
  localparam logic [RMW-1:0] RC_MUL =
    RMW'(((64'd1 << RS) + 64'(PCT_DEN) - 64'd1) / 64'(PCT_DEN));

  // frame state
  logic [CW-1:0]     count_r;
  logic [SW-1:0]     sum_r;
  logic              ovf_r;
  logic [PB-1:0]     mem [MAX_SAMPLES];
  logic [PB-1:0]     diff;
  logic              wr_en;

  // selection state
  logic [AW-1:0]     addr_r;
  logic [BW-1:0]     bit_r;
  logic [PB-1:0]     rd_data_r;
  logic              rd_vld_r;
  logic [PB-1:0]     pref_a_r, pref_b_r;
  logic [CW-1:0]     rank_a_r, rank_b_r;
  logic [CW-1:0]     cnt_a_r, cnt_b_r;
  logic [PB-1:0]     hmask;
  logic              hit_a, hit_b;

  // arithmetic state
  logic [FRAC_W-1:0] frac_r;
  logic [PW-1:0]     pa_r, pb_r;
  logic [MEAN_W-1:0] mean_r;
  logic [P95_W-1:0]  p95_r;
  logic [NW-1:0]     div_num;
  logic [DVW-1:0]    div_den;
  logic              div_go;
  logic              div_done;
  logic [NW-1:0]     div_quot;
  logic [CW-1:0]     idx_i;

  // reciprocal divide by 100
  logic              rc_go;
  logic [RW-1:0]     rc_x;
  logic [RW-1:0]     rc_x_r;
  logic [RPW-1:0]    rc_prod;
  logic [QW-1:0]     rc_q_r;
  logic [RW-1:0]     rc_rem;
  logic              rc_v1_r, rc_v2_r;

  // output register
  logic              out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [P95_W-1:0]  out_p95_r;
  logic              out_ovf_r;

  // absolute difference and store write enable
  always_comb begin
    diff  = (ref_pixel >= dist_pixel) ? (ref_pixel - dist_pixel) : (dist_pixel - ref_pixel);
    wr_en = cmd.take && in_mask && (count_r < CW'(MAX_SAMPLES));
  end

  // count, sum and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load_out) begin
      count_r <= '0;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.take && in_mask) begin
      if (wr_en) begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SW'(diff);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // difference store
  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[AW-1:0]] <= diff;
    if (cmd.sel_rd) rd_data_r <= mem[addr_r];
  end

  // operand selection: mean goes to the serial divider, divides by 100 to the reciprocal
  always_comb begin
    div_num = NW'(sum_r) + NW'(count_r >> 1);
    div_den = DVW'(count_r);
    div_go  = cmd.div_go && (cmd.div_sel == DIV_MEAN);
    rc_go   = cmd.div_go && (cmd.div_sel != DIV_MEAN);
    rc_x    = '0;
    unique case (cmd.div_sel)
      DIV_IDX: rc_x = RW'(count_r - 1'b1) * RW'(PCT_NUM);
      DIV_P95: rc_x = RW'(pa_r) + RW'(pb_r) + RW'(PCT_HALF);
      default: ;
    endcase
  end

  madp95_div #(.NW(NW), .DVW(DVW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // quotient by reciprocal multiply, remainder by multiply back and subtract
  always_comb begin
    rc_prod = RPW'(rc_x_r) * RPW'(RC_MUL);
    rc_rem  = rc_x_r - RW'(rc_q_r) * RW'(PCT_DEN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_v1_r <= 1'b0;
      rc_v2_r <= 1'b0;
    end else begin
      rc_v1_r <= rc_go;
      rc_v2_r <= rc_v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rc_go)   rc_x_r <= rc_x;
    if (rc_v1_r) rc_q_r <= rc_prod[RS +: QW];
  end

  // candidate match for the current bit: upper bits equal the prefix, this bit zero
  always_comb begin
    hmask = ~({PB{1'b1}} >> (PB - 1 - 32'(bit_r)));
    hit_a = (((rd_data_r ^ pref_a_r) & hmask) == '0) && !rd_data_r[bit_r];
    hit_b = (((rd_data_r ^ pref_b_r) & hmask) == '0) && !rd_data_r[bit_r];
    idx_i = rc_q_r[CW-1:0];
  end

  // radix selection of order statistics i and j
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.sel_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_idx) begin
      frac_r   <= rc_rem[FRAC_W-1:0];
      rank_a_r <= idx_i;
      rank_b_r <= ((idx_i + 1'b1) < count_r) ? idx_i + 1'b1 : count_r - 1'b1;
      pref_a_r <= '0;
      pref_b_r <= '0;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      addr_r   <= '0;
      bit_r    <= BW'(PB - 1);
    end else if (cmd.sel_upd) begin
      if (rank_a_r >= cnt_a_r) begin
        pref_a_r[bit_r] <= 1'b1;
        rank_a_r        <= rank_a_r - cnt_a_r;
      end
      if (rank_b_r >= cnt_b_r) begin
        pref_b_r[bit_r] <= 1'b1;
        rank_b_r        <= rank_b_r - cnt_b_r;
      end
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      addr_r  <= '0;
      bit_r   <= bit_r - 1'b1;
    end else begin
      if (cmd.sel_rd) addr_r <= addr_r + 1'b1;
      if (rd_vld_r) begin
        cnt_a_r <= cnt_a_r + CW'(hit_a);
        cnt_b_r <= cnt_b_r + CW'(hit_b);
      end
    end
  end

  // interpolation products, mean and percentile capture
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pa_r <= PW'(FRAC_W'(PCT_DEN) - frac_r) * PW'(pref_a_r);
      pb_r <= PW'(frac_r) * PW'(pref_b_r);
    end
    if (cmd.cap_zero) begin
      mean_r <= '0;
      p95_r  <= '0;
    end
    if (cmd.cap_mean) mean_r <= div_quot[MEAN_W-1:0];
    if (cmd.cap_p95)  p95_r  <= rc_q_r[P95_W-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_count_r <= COUNT_W'(count_r);
      out_mean_r  <= mean_r;
      out_p95_r   <= p95_r;
      out_ovf_r   <= ovf_r;
    end
  end

  // status
  always_comb begin
    sts.n_zero    = (count_r == '0);
    sts.div_done  = div_done || rc_v2_r;
    sts.addr_last = (CW'(addr_r) == count_r - 1'b1);
    sts.bit_last  = (bit_r == '0);
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign masked_count  = out_count_r;
  assign mean_abs_diff = out_mean_r;
  assign p95_abs_diff  = out_p95_r;
  assign overflowed    = out_ovf_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SAMPLES))
    else $error("stored count beyond capacity");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> pref_a_r <= pref_b_r)
    else $error("order statistic i above statistic j");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (count_r == '0) && (sum_r == '0) && !ovf_r)
    else $error("frame state not cleared after result");

endmodule

[sv/masked_absdiff_mean_p95_unit.sv]
// Masked mean absolute difference and 95th percentile, top level.
// One pixel transfer per cycle; from the last transfer until the result loads, in_ready is low.
// After the last transfer the result comes from a serial mean divide of NW quotient bits,
// NW = max(PIXEL_BITS+clog2(MAX_SAMPLES+1)+1, PIXEL_BITS+7, 17), then a radix selection
// that scans the store once per result bit. An empty frame skips both and loads zeros.
// Synchronous active-low reset clears control and frame counters; the store is not cleared.
`timescale 1ns / 1ps

module masked_absdiff_mean_p95_unit #(
  parameter int unsigned MAX_SAMPLES = madp95_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned PIXEL_BITS  = madp95_pkg::PIXEL_BITS_DEF
) (
  input logic           clk,
  input logic           rst_n,
  madp95_in_if.sink     in_ch,
  madp95_out_if.source  out_ch
);
  import madp95_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  madp95_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_pixel),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  madp95_dpath #(.MAX_SAMPLES(MAX_SAMPLES), .PIXEL_BITS(PIXEL_BITS)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .ref_pixel     (in_ch.ref_pixel),
    .dist_pixel    (in_ch.dist_pixel),
    .in_mask       (in_ch.in_mask),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .masked_count  (out_ch.masked_count),
    .mean_abs_diff (out_ch.mean_abs_diff),
    .p95_abs_diff  (out_ch.p95_abs_diff),
    .overflowed    (out_ch.overflowed)
  );

  assign in_ch.ready = in_ready;

endmodule

[tb/masked_absdiff_mean_p95_unit_tb.sv]
// testbench for masked_absdiff_mean_p95_unit: directed frames, then random frames
// checked against an in-bench predictor of count, rounded mean and interpolated p95
// depends on madp95_pkg, madp95_in_if, madp95_out_if and the unit itself
`timescale 1ns / 1ps

module masked_absdiff_mean_p95_unit_tb;
  import madp95_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_SAMPLES_DEF;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean;
    logic [P95_W-1:0]   p95;
    logic               ovf;
  } frame_result_t;

  typedef struct {
    logic [15:0]   ref_px;
    logic [15:0]   dist_px;
    logic          mask;
    logic          last;
    logic          typed;
    frame_result_t want;
  } pixel_row_t;

  logic clk;
  logic rst_n;

  madp95_in_if  in_if ();
  madp95_out_if out_if ();

  masked_absdiff_mean_p95_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predictor state for the current frame
  logic [15:0]   frame_diffs[$];
  logic [63:0]   frame_sum;
  logic          frame_ovf;
  frame_result_t frame_results[$];

  // directed stimulus table
  pixel_row_t    rows[$];

  // typed expectation for the transfer being driven
  logic          row_typed;
  frame_result_t row_want;

  bit     failed;
  bit     idle_on;
  int     quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // fold one pixel into the frame, return the frame result on the last pixel
  function automatic frame_result_t absdiff_frame_step(logic [15:0] a, logic [15:0] b,
                                                       logic m, logic last, output bit fired);
    frame_result_t res;
    logic [15:0]   d;
    logic [15:0]   ordered[$];
    int unsigned   n;
    longint unsigned pos, r, lo, hi;
    int unsigned   i, j;
    res = '0;
    fired = 1'b0;
    if (m) begin
      d = (a >= b) ? a - b : b - a;
      if (frame_diffs.size() < STORE_DEPTH) begin
        frame_diffs.insert(frame_diffs.size(), d);
        frame_sum += 64'(d);
      end else begin
        frame_ovf = 1'b1;
      end
    end
    if (last) begin
      fired = 1'b1;
      n = frame_diffs.size();
      res.count = COUNT_W'(n);
      res.ovf = frame_ovf;
      if (n > 0) begin
        ordered = frame_diffs;
        ordered.sort();
        pos = 95 * longint'(n - 1);
        i = 32'(pos / 100);
        r = pos % 100;
        j = (i + 1 < n) ? i + 1 : n - 1;
        lo = 64'(ordered[i]);
        hi = 64'(ordered[j]);
        res.mean = MEAN_W'((frame_sum + 64'(n / 2)) / 64'(n));
        res.p95 = P95_W'(((100 - r) * lo + r * hi + 50) / 100);
      end
      frame_diffs.delete();
      frame_sum = 0;
      frame_ovf = 1'b0;
    end
    return res;
  endfunction

  // append one row to the directed table
  function automatic void add_row(pixel_row_t row);
    rows.insert(rows.size(), row);
  endfunction

  // input transfers feed the predictor
  always @(posedge clk) begin
    frame_result_t res;
    bit fired;
    if (rst_n && in_if.valid && in_if.ready) begin
      res = absdiff_frame_step(in_if.ref_pixel, in_if.dist_pixel, in_if.in_mask,
                               in_if.last_pixel, fired);
      if (fired) frame_results.insert(frame_results.size(), row_typed ? row_want : res);
    end
  end

  // result transfers are checked against the oldest expectation
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (frame_results.size() == 0) begin
        $display("%0t: unexpected result count=%0d mean=%0d p95=%0d ovf=%0d", $time,
                 out_if.masked_count, out_if.mean_abs_diff, out_if.p95_abs_diff,
                 out_if.overflowed);
        failed = 1'b1;
      end else begin
        want = frame_results.pop_front();
        if (out_if.masked_count !== want.count) begin
          $display("%0t: masked_count expected %0d actual %0d", $time, want.count,
                   out_if.masked_count);
          failed = 1'b1;
        end
        if (out_if.mean_abs_diff !== want.mean) begin
          $display("%0t: mean_abs_diff expected %0d actual %0d", $time, want.mean,
                   out_if.mean_abs_diff);
          failed = 1'b1;
        end
        if (out_if.p95_abs_diff !== want.p95) begin
          $display("%0t: p95_abs_diff expected %0d actual %0d", $time, want.p95,
                   out_if.p95_abs_diff);
          failed = 1'b1;
        end
        if (out_if.overflowed !== want.ovf) begin
          $display("%0t: overflowed expected %0d actual %0d", $time, want.ovf,
                   out_if.overflowed);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result-side backpressure in bursts
  initial begin
    int len;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        len = $urandom_range(1, 9);
      end else begin
        out_if.ready <= 1'b1;
        len = $urandom_range(1, 20);
      end
      repeat (len - 1) @(negedge clk);
    end
  end

  // drive one pixel and wait for its transfer
  task automatic send_pixel(logic [15:0] a, logic [15:0] b, logic m, logic last,
                            logic typed, frame_result_t want);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.ref_pixel  <= a;
    in_if.dist_pixel <= b;
    in_if.in_mask    <= m;
    in_if.last_pixel <= last;
    row_typed        <= typed;
    row_want         <= want;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'(16'h8000 + $urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    pixel_row_t    row;
    frame_result_t none;
    int            frame_len, density, p, sent;
    logic          m;

    none = '0;
    failed = 1'b0;
    idle_on = 1'b1;
    quiet_cycles = 0;
    frame_sum = 0;
    frame_ovf = 1'b0;
    row_typed = 1'b0;
    row_want = '0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.ref_pixel = '0;
    in_if.dist_pixel = '0;
    in_if.in_mask = 1'b0;
    in_if.last_pixel = 1'b0;

    // directed rows: ref, dist, mask, last, typed, expected {count, mean, p95, ovf}
    add_row('{16'h1234, 16'h0042, 1'b0, 1'b1, 1'b1, '{15'd0, 16'd0, 16'd0, 1'b0}});
    add_row('{16'hffff, 16'h0000, 1'b1, 1'b1, 1'b1, '{15'd1, 16'hffff, 16'hffff, 1'b0}});
    add_row('{16'h0000, 16'hffff, 1'b1, 1'b1, 1'b1, '{15'd1, 16'hffff, 16'hffff, 1'b0}});
    add_row('{16'h5a5a, 16'h5a5a, 1'b1, 1'b1, 1'b1, '{15'd1, 16'd0, 16'd0, 1'b0}});
    add_row('{16'hffff, 16'hffff, 1'b0, 1'b0, 1'b0, none});
    add_row('{16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1, '{15'd0, 16'd0, 16'd0, 1'b0}});
    // two-pixel frame: rounding of the mean and interpolation between neighbors
    add_row('{16'h0000, 16'h0001, 1'b1, 1'b0, 1'b0, none});
    add_row('{16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, none});
    // mixed frame with unmasked pixels in between
    add_row('{16'h1200, 16'h1234, 1'b1, 1'b0, 1'b0, none});
    add_row('{16'hffff, 16'h0000, 1'b0, 1'b0, 1'b0, none});
    add_row('{16'h8000, 16'h7fff, 1'b1, 1'b0, 1'b0, none});
    add_row('{16'h00ff, 16'hff00, 1'b1, 1'b0, 1'b0, none});
    add_row('{16'haaaa, 16'h5555, 1'b1, 1'b0, 1'b0, none});
    add_row('{16'h0000, 16'hffff, 1'b1, 1'b0, 1'b0, none});
    add_row('{16'h3c3c, 16'hc3c3, 1'b0, 1'b1, 1'b0, none});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[k]) begin
      row = rows[k];
      send_pixel(row.ref_px, row.dist_px, row.mask, row.last, row.typed, row.want);
    end

    // random frames, each ending with a last pixel, with varying mask density
    sent = 0;
    while (sent < 1800) begin
      if (sent > 1500) idle_on = 1'b0;
      frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 30);
      density = $urandom_range(0, 4);
      for (p = 0; p < frame_len; p++) begin
        m = (density == 4) ? 1'b1 : ($urandom_range(0, 3) < density);
        send_pixel(pick_pixel(), pick_pixel(), m, p == frame_len - 1, 1'b0, none);
      end
      sent += frame_len;
    end
    in_if.valid <= 1'b0;

    while (frame_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    if (!failed && frame_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
